[design/fqpr_pkg.sv]
// ----------------------------------------------------------------------------
// fqpr_pkg
// Shared types and constants of the FIFO queue with peek and reverse.
// ----------------------------------------------------------------------------
package fqpr_pkg;

  // Fixed field widths of the word channels
  localparam int unsigned CmdW    = 2;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_REV  = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming command word
    logic exec;     // check, update pointers, access the store
    logic publish;  // load the result register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy; // result register holds a word not yet taken
  } dp_stat_t;

endpackage

[design/fqpr_in_if.sv]
// ----------------------------------------------------------------------------
// fqpr_in_if
// Command channel: valid/ready handshake with command, value and index.
// ----------------------------------------------------------------------------
interface fqpr_in_if import fqpr_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [ValueW-1:0] value;
  logic [IndexW-1:0] index;

  modport source (output valid, command, value, index, input ready);
  modport sink   (input valid, command, value, index, output ready);

endinterface

[design/fqpr_out_if.sv]
// ----------------------------------------------------------------------------
// fqpr_out_if
// Result channel: valid/ready handshake with read data, status and count.
// ----------------------------------------------------------------------------
interface fqpr_out_if import fqpr_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [ValueW-1:0]  read_data;
  logic [StatusW-1:0] status;
  logic [CountW-1:0]  count;

  modport source (output valid, read_data, status, count, input ready);
  modport sink   (input valid, read_data, status, count, output ready);

endinterface

[design/fqpr_ctrl.sv]
// ----------------------------------------------------------------------------
// fqpr_ctrl
// Sequencer: accept a word, execute it, then hand the result to the output.
// ----------------------------------------------------------------------------
module fqpr_ctrl import fqpr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_free;

  assign out_free   = !stat_i.out_busy || out_ready_i;
  assign in_ready_o = in_ready_q;

  assign cmd_o.capture = in_valid_i && in_ready_q;
  assign cmd_o.exec    = (state_q == S_EXEC);
  assign cmd_o.publish = (state_q == S_RESP) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            state_q    <= S_EXEC;
            in_ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          // hold until the result register can take the word
          if (out_free) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

[design/fqpr_dp.sv]
// ----------------------------------------------------------------------------
// fqpr_dp
// Ring store, head/count/direction registers and the result register.
// ----------------------------------------------------------------------------
module fqpr_dp import fqpr_pkg::*; #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_stat_t           stat_o,
  input  logic [CmdW-1:0]    in_command_i,
  input  logic [ValueW-1:0]  in_value_i,
  input  logic [IndexW-1:0]  in_index_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [ValueW-1:0]  out_read_data_o,
  output logic [StatusW-1:0] out_status_o,
  output logic [CountW-1:0]  out_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > IndexW) ? CW : IndexW;
  localparam logic [AW-1:0] LastSlot  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // latched command word
  cmd_e                  cmd_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [IndexW-1:0]     idx_q;

  // queue state
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          rev_q, rev_d;

  // execute results
  status_e               status_q, status_d;
  logic                  rd_hit_q;
  logic [DATA_WIDTH-1:0] rdata_q;
  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // result register
  logic               out_valid_q;
  logic [ValueW-1:0]  out_data_q;
  logic [StatusW-1:0] out_status_q;
  logic [CountW-1:0]  out_count_q;

  logic          is_full, is_empty, bad_index, ok;
  logic [CW-1:0] rd_k, rd_off;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          do_wr, do_rd;

  assign is_full   = (count_q == FullCount);
  assign is_empty  = (count_q == '0);
  assign bad_index = (XW'(idx_q) >= XW'(count_q));

  always_comb begin
    case (cmd_q)
      CMD_ENQ:  status_d = is_full   ? ST_FULL  : ST_OK;
      CMD_DEQ:  status_d = is_empty  ? ST_EMPTY : ST_OK;
      CMD_PEEK: status_d = bad_index ? ST_RANGE : ST_OK;
      CMD_REV:  status_d = ST_OK;
      default:  status_d = ST_OK;
    endcase
  end

  assign ok = (status_d == ST_OK);

  // logical position to slot; when reversed, positions count down from head + count - 1
  assign rd_k    = (cmd_q == CMD_PEEK) ? CW'(XW'(idx_q)) : '0;
  assign rd_off  = rev_q ? (count_q - CW'(1) - rd_k) : rd_k;
  assign rd_addr = ring_add(head_q, AW'(rd_off));
  assign wr_addr = rev_q ? ring_add(head_q, LastSlot) : ring_add(head_q, AW'(count_q));

  assign do_wr = cmd_i.exec && ok && (cmd_q == CMD_ENQ);
  assign do_rd = cmd_i.exec && ok && ((cmd_q == CMD_DEQ) || (cmd_q == CMD_PEEK));

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    rev_d   = rev_q;
    if (cmd_i.exec && ok) begin
      case (cmd_q)
        CMD_ENQ: begin
          count_d = count_q + CW'(1);
          if (rev_q) begin
            head_d = wr_addr;
          end
        end
        CMD_DEQ: begin
          count_d = count_q - CW'(1);
          if (!rev_q) begin
            head_d = ring_add(head_q, AW'(1));
          end
        end
        CMD_REV: begin
          rev_d = !rev_q;
        end
        default: begin
          head_d = head_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      rev_q   <= rev_d;
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= cmd_e'(in_command_i);
      val_q <= in_value_i[DATA_WIDTH-1:0];
      idx_q <= in_index_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      rd_hit_q <= do_rd;
    end
    if (cmd_i.publish) begin
      out_data_q   <= rd_hit_q ? ValueW'(rdata_q) : '0;
      out_status_q <= status_q;
      out_count_q  <= CountW'(count_q);
    end
  end

  // single-port style store: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wr_addr] <= val_q;
    end
    if (do_rd) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign stat_o.out_busy = out_valid_q;
  assign out_valid_o     = out_valid_q;
  assign out_read_data_o = out_data_q;
  assign out_status_o    = out_status_q;
  assign out_count_o     = out_count_q;

endmodule

[design/fifo_queue_with_peek_reverse_unit.sv]
// ----------------------------------------------------------------------------
// fifo_queue_with_peek_reverse_unit
// Bounded FIFO of data words with enqueue, dequeue, peek and whole-queue
// reversal; each command word yields one result word.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake          Payload
//   -------  ---  -----------------  ---------------------------------------
//   cmd_i    in   valid / ready      command[1:0], value[63:0], index[3:0]
//   rsp_o    out  valid / ready      read_data[63:0], status[1:0], count[4:0]
//
// Each command word passes through capture, execute (status check,
// pointer update and at most one access to the ring store), and result
// load. The store's registered read port sets the execute-to-result step.
// Reset clears head, count and direction; the store is not cleared.
// A stalled result holds in the output register; the next command word is
// accepted while it waits, and the sequencer holds in its result step until
// the register frees up.
// ----------------------------------------------------------------------------
module fifo_queue_with_peek_reverse_unit import fqpr_pkg::*; #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fqpr_in_if.sink   cmd_i,
  fqpr_out_if.source rsp_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer: one command word in flight at a time
  fqpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_ready_i (rsp_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  // ring store plus head/count/direction and the result register
  fqpr_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .stat_o          (dp_stat),
    .in_command_i    (cmd_i.command),
    .in_value_i      (cmd_i.value),
    .in_index_i      (cmd_i.index),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .out_read_data_o (rsp_o.read_data),
    .out_status_o    (rsp_o.status),
    .out_count_o     (rsp_o.count)
  );

endmodule

[design/fqpr_checker.sv]
// ----------------------------------------------------------------------------
// fqpr_checker
// Port-level checks of the FIFO queue unit, bound to the top level.
// ----------------------------------------------------------------------------
module fqpr_checker import fqpr_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [ValueW-1:0]  read_data_i,
  input logic [StatusW-1:0] status_i,
  input logic [CountW-1:0]  count_i
);

  localparam logic [CountW-1:0] FullCount = CountW'(DEPTH);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(read_data_i)
      && $stable(status_i) && $stable(count_i))
    else $error("result word changed while stalled");

  // one command word at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command accepted while another is in flight");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK) |-> read_data_i == '0)
    else $error("nonzero read data on error");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_EMPTY) |-> count_i == '0)
    else $error("empty status with nonzero count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_FULL) |-> count_i == FullCount)
    else $error("full status with count below depth");

endmodule

bind fifo_queue_with_peek_reverse_unit fqpr_checker #(
  .DEPTH (DEPTH)
) u_fqpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cmd_i.valid),
  .in_ready_i  (cmd_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .read_data_i (rsp_o.read_data),
  .status_i    (rsp_o.status),
  .count_i     (rsp_o.count)
);

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FIFO queue with peek and reverse. A directed
// table covers empty, full and out-of-range errors, reversal and extreme
// words. Random bursts follow, biased to fill, to drain or to balance the
// queue. A ring model in the bench tracks head, count and direction and
// checks every result word in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fqpr_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned DRAIN_CYCLES = 10;       // quiet cycles after the last word
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned RANDOM_ITEMS = 1050;

  typedef struct packed {
    logic [ValueW-1:0] data;
    status_e           status;
    logic [CountW-1:0] count;
  } rsp_t;

  // One line of the directed table; a repeated command adds k to the value
  typedef struct packed {
    cmd_e              cmd;
    logic [ValueW-1:0] value;
    logic [IndexW-1:0] index;
    logic [4:0]        reps;
    logic              typed;  // result below is written out by hand
    rsp_t              want;
  } row_t;

  localparam logic [ValueW-1:0] ONES = {ValueW{1'b1}};

  localparam row_t PLAN [19] = '{
    // Errors and reversal on an empty queue
    '{CMD_DEQ,  64'd0, 4'd0,  5'd1,  1'b1, '{64'd0, ST_EMPTY, 5'd0}},
    '{CMD_PEEK, 64'd0, 4'd0,  5'd1,  1'b1, '{64'd0, ST_RANGE, 5'd0}},
    '{CMD_REV,  64'd0, 4'd0,  5'd1,  1'b1, '{64'd0, ST_OK,    5'd0}},
    '{CMD_REV,  ONES,  4'd15, 5'd1,  1'b1, '{64'd0, ST_OK,    5'd0}},
    // Extreme words, then a peek past the count
    '{CMD_ENQ,  64'd0, 4'd0,  5'd1,  1'b1, '{64'd0, ST_OK,    5'd1}},
    '{CMD_ENQ,  ONES,  4'd15, 5'd1,  1'b1, '{64'd0, ST_OK,    5'd2}},
    '{CMD_PEEK, 64'd0, 4'd15, 5'd1,  1'b1, '{64'd0, ST_RANGE, 5'd2}},
    '{CMD_PEEK, 64'd0, 4'd1,  5'd1,  1'b0, '{64'd0, ST_OK,    5'd0}},
    '{CMD_REV,  64'd0, 4'd0,  5'd1,  1'b1, '{64'd0, ST_OK,    5'd2}},
    '{CMD_PEEK, 64'd0, 4'd0,  5'd1,  1'b0, '{64'd0, ST_OK,    5'd0}},
    '{CMD_DEQ,  64'd0, 4'd0,  5'd1,  1'b0, '{64'd0, ST_OK,    5'd0}},
    // Fill up in reversed order, then hit the full error
    '{CMD_ENQ,  64'hA5A5_5A5A_0000_0001, 4'd0, 5'd15, 1'b0, '{64'd0, ST_OK, 5'd0}},
    '{CMD_ENQ,  64'h1234_5678_9ABC_DEF0, 4'd0, 5'd1,  1'b1, '{64'd0, ST_FULL, 5'd16}},
    '{CMD_PEEK, 64'd0, 4'd15, 5'd1,  1'b0, '{64'd0, ST_OK,    5'd0}},
    '{CMD_REV,  64'd0, 4'd0,  5'd1,  1'b1, '{64'd0, ST_OK,    5'd16}},
    '{CMD_PEEK, 64'd0, 4'd15, 5'd1,  1'b0, '{64'd0, ST_OK,    5'd0}},
    '{CMD_DEQ,  64'd0, 4'd0,  5'd1,  1'b0, '{64'd0, ST_OK,    5'd0}},
    '{CMD_ENQ,  64'h8000_0000_0000_0000, 4'd0, 5'd1, 1'b0, '{64'd0, ST_OK, 5'd0}},
    '{CMD_DEQ,  64'd0, 4'd0,  5'd3,  1'b0, '{64'd0, ST_OK,    5'd0}}
  };

  logic clk_i;
  logic rst_ni;

  fqpr_in_if  cmd_if ();
  fqpr_out_if rsp_if ();

  fifo_queue_with_peek_reverse_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // --------------------------------------------------------------------------
  // Ring model of the queue: front slot, entries held and direction flag
  // --------------------------------------------------------------------------
  logic [ValueW-1:0] ring_mem [DEPTH];
  int unsigned       front_slot;
  int unsigned       held;
  bit                flipped;

  rsp_t        rsp_due [$];   // result words still owed by the block, oldest first
  int unsigned mismatches;
  int unsigned cycles;
  bit          steady;        // no idling on either channel during this burst

  // Physical slot of logical position k, counted from the front
  function automatic int unsigned slot_at(int unsigned k);
    if (flipped) begin
      return (front_slot + held - 1 - k) % DEPTH;
    end
    return (front_slot + k) % DEPTH;
  endfunction

  // Apply one command word to the ring model; return the result word it owes
  function automatic rsp_t apply_cmd(cmd_e c, logic [ValueW-1:0] v, logic [IndexW-1:0] ix);
    rsp_t r;
    r.data   = '0;
    r.status = ST_OK;
    case (c)
      CMD_ENQ: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else if (flipped) begin
          // Back sits at the front slot; grow the ring downward
          front_slot = (front_slot + DEPTH - 1) % DEPTH;
          ring_mem[front_slot] = v;
          held++;
        end else begin
          ring_mem[(front_slot + held) % DEPTH] = v;
          held++;
        end
      end
      CMD_DEQ: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = ring_mem[slot_at(0)];
          if (!flipped) begin
            front_slot = (front_slot + 1) % DEPTH;
          end
          held--;
        end
      end
      CMD_PEEK: begin
        if (ix >= held) begin
          r.status = ST_RANGE;
        end else begin
          r.data = ring_mem[slot_at(ix)];
        end
      end
      default: begin
        flipped = !flipped;
      end
    endcase
    r.count = held[CountW-1:0];
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Drive one command word, hold it until accepted, then log its result.
  // Called at a rising edge; leaves valid high at the accepting edge.
  task automatic send_word(cmd_e c, logic [ValueW-1:0] v, logic [IndexW-1:0] ix,
                           bit typed, rsp_t want);
    rsp_t        r;
    int unsigned g;
    g = pick_gap();
    if (g > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= c;
    cmd_if.value   <= v;
    cmd_if.index   <= ix;
    do @(posedge clk_i); while (!cmd_if.ready);
    r = apply_cmd(c, v, ix);
    rsp_due.push_back(typed ? want : r);
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and cycle limit
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    cycles = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls on ready
  // --------------------------------------------------------------------------
  initial begin
    int unsigned g;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      g = pick_gap();
      if (g > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Check every accepted result word against the oldest owed one
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (rsp_due.size() == 0) begin
        $display("%0t: unexpected result word data=%h status=%0d count=%0d",
                 $time, rsp_if.read_data, rsp_if.status, rsp_if.count);
        mismatches++;
      end else begin
        want = rsp_due.pop_front();
        if (rsp_if.read_data !== want.data) begin
          $display("%0t: read_data expected %h actual %h",
                   $time, want.data, rsp_if.read_data);
          mismatches++;
        end
        if (rsp_if.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_if.status);
          mismatches++;
        end
        if (rsp_if.count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, rsp_if.count);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command side: directed table, then random bursts
  // --------------------------------------------------------------------------
  initial begin
    rsp_t              none;
    cmd_e              c;
    logic [ValueW-1:0] v;
    logic [IndexW-1:0] ix;
    int unsigned       sent;
    int unsigned       burst;
    int unsigned       len;
    int unsigned       mode;
    int unsigned       r;

    none           = '{64'd0, ST_OK, 5'd0};
    mismatches     = 0;
    steady         = 1'b0;
    front_slot     = 0;
    held           = 0;
    flipped        = 1'b0;
    rst_ni         = 1'b0;
    cmd_if.valid   <= 1'b0;
    cmd_if.command <= CMD_ENQ;
    cmd_if.value   <= '0;
    cmd_if.index   <= '0;

    // Hold reset low at the start, then release it
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (PLAN[i]) begin
      for (int unsigned k = 0; k < PLAN[i].reps; k++) begin
        send_word(PLAN[i].cmd, PLAN[i].value + k, PLAN[i].index,
                  PLAN[i].typed, PLAN[i].want);
      end
    end

    // Random bursts: each one leans toward filling, draining or balance
    sent  = 0;
    burst = 0;
    while (sent < RANDOM_ITEMS) begin
      mode   = $urandom_range(2);
      steady = ($urandom_range(4) == 0);
      len    = $urandom_range(10, 60);

      // Once, drop valid and wait for every owed result before going on
      if (burst == 4) begin
        cmd_if.valid <= 1'b0;
        @(posedge clk_i);
        while (rsp_due.size() != 0) @(posedge clk_i);
      end

      repeat (len) begin
        r = $urandom_range(99);
        case (mode)
          0:       c = (r < 55) ? CMD_ENQ : (r < 70) ? CMD_DEQ : (r < 90) ? CMD_PEEK : CMD_REV;
          1:       c = (r < 15) ? CMD_ENQ : (r < 70) ? CMD_DEQ : (r < 90) ? CMD_PEEK : CMD_REV;
          default: c = (r < 35) ? CMD_ENQ : (r < 65) ? CMD_DEQ : (r < 90) ? CMD_PEEK : CMD_REV;
        endcase

        r = $urandom_range(99);
        if (r < 10) begin
          v = '0;
        end else if (r < 20) begin
          v = ONES;
        end else begin
          v = {$urandom, $urandom};
        end

        // Peek mostly inside the queue, sometimes anywhere
        if (held > 0 && $urandom_range(9) < 8) begin
          ix = IndexW'($urandom_range(held - 1));
        end else begin
          ix = IndexW'($urandom_range(15));
        end

        send_word(c, v, ix, 1'b0, none);
      end
      sent += len;
      burst++;
    end

    // Release the channel, drain owed results, then let the pipeline settle
    steady       = 1'b0;
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (rsp_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
design/fqpr_pkg.sv
design/fqpr_in_if.sv
design/fqpr_out_if.sv
design/fqpr_ctrl.sv
design/fqpr_dp.sv
design/fifo_queue_with_peek_reverse_unit.sv
design/fqpr_checker.sv
sim/tb.sv
